// ===== rtl/min_heap_priority_queue_unit_defines.svh =====
// assertion macros shared by the min-heap priority queue rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MHPQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define MHPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
// types, constants and helpers for the min-heap priority queue
// used by mhpq_ctrl, mhpq_dp and the top level; no dependencies
package mhpq_pkg;

    localparam int CAPACITY  = 32;
    localparam int ADDR_W    = 16;
    localparam int DIST_W    = 16;
    localparam int CNT_W     = 6;
    localparam int SLOT_W    = $clog2(CAPACITY + 1);
    localparam int MEM_AW    = $clog2(CAPACITY);
    localparam int ENTRY_W   = ADDR_W + DIST_W + 1;
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int RESULT_W  = ENTRY_W + CNT_W + 2;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // address in the lowest bits, as on the stream
    typedef struct packed {
        logic              visited;
        logic [DIST_W-1:0] distance;
        logic [ADDR_W-1:0] address;
    } entry_t;

    typedef struct packed {
        logic             is_full;
        logic             is_empty;
        logic [CNT_W-1:0] entry_count;
        entry_t           entry;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_ITEM,
        OP_START_PUSH,
        OP_RD_PARENT,
        OP_MOVE_UP,
        OP_PLACE_PUSH,
        OP_RD_LAST,
        OP_TAKE_LAST,
        OP_RD_CHILD,
        OP_MOVE_DOWN,
        OP_PLACE_POP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_load;
        logic   res_ok;
        logic   res_pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic has_parent;
        logic up_lt;
        logic has_left;
        logic down_gt;
        logic out_free;
    } dp_stat_t;

    // heap slots count from 1, memory rows from 0
    function automatic logic [MEM_AW-1:0] slot_to_addr(input logic [SLOT_W:0] slot);
        logic [SLOT_W:0] row;
        row = slot - 1'b1;
        return row[MEM_AW-1:0];
    endfunction

endpackage

// ===== rtl/mhpq_dp.sv =====
// datapath of the min-heap priority queue: heap memory, count, working
// registers and the result register; depends on mhpq_pkg and the defines header
`include "min_heap_priority_queue_unit_defines.svh"

module mhpq_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  mhpq_pkg::ctrl_cmd_t             cmd,
    output mhpq_pkg::dp_stat_t              stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);
    import mhpq_pkg::*;

    entry_t            heap_mem [CAPACITY];
    entry_t            rd_a_reg, rd_b_reg;
    entry_t            item_reg, item_next;
    entry_t            root_reg, top_reg;
    logic              kind_reg;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    result_t           out_reg;
    logic              out_ok_reg;
    logic              out_valid_reg;

    logic [SLOT_W:0]   count_ext, slot_ext, parent_slot, left_slot, right_slot;
    logic              has_right, take_right;
    entry_t            chosen;
    logic [SLOT_W:0]   chosen_slot;
    logic [MEM_AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic              rd_en_a, rd_en_b, wr_en;
    entry_t            wr_data;
    entry_t            res_entry;

    assign count_ext   = {1'b0, count_reg};
    assign slot_ext    = {1'b0, slot_reg};
    assign parent_slot = slot_ext >> 1;
    assign left_slot   = {slot_reg, 1'b0};
    assign right_slot  = {slot_reg, 1'b1};
    assign has_right   = right_slot <= count_ext;

    // right child only when strictly smaller than the left
    assign take_right  = has_right && (rd_a_reg.distance > rd_b_reg.distance);
    assign chosen      = take_right ? rd_b_reg : rd_a_reg;
    assign chosen_slot = take_right ? right_slot : left_slot;

    always_comb begin
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = slot_to_addr(left_slot);
        rd_addr_b = slot_to_addr(right_slot);
        wr_en     = 1'b0;
        wr_addr   = slot_to_addr(slot_ext);
        wr_data   = item_reg;
        item_next = item_reg;
        slot_next = slot_reg;
        count_next = count_reg;
        unique case (cmd.op)
            OP_LOAD_ITEM: begin
                item_next = entry_t'(s_tdata[ENTRY_W-1:0]);
            end
            OP_START_PUSH: begin
                slot_next = count_reg + 1'b1;
            end
            OP_RD_PARENT: begin
                rd_en_a   = 1'b1;
                rd_addr_a = slot_to_addr(parent_slot);
            end
            OP_MOVE_UP: begin
                wr_en     = 1'b1;
                wr_data   = rd_a_reg;
                slot_next = parent_slot[SLOT_W-1:0];
            end
            OP_PLACE_PUSH: begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
            OP_RD_LAST: begin
                rd_en_a   = 1'b1;
                rd_addr_a = slot_to_addr(count_ext);
            end
            OP_TAKE_LAST: begin
                item_next  = rd_a_reg;
                count_next = count_reg - 1'b1;
                slot_next  = SLOT_W'(1);
            end
            OP_RD_CHILD: begin
                rd_en_a = 1'b1;
                rd_en_b = 1'b1;
            end
            OP_MOVE_DOWN: begin
                wr_en     = 1'b1;
                wr_data   = chosen;
                slot_next = chosen_slot[SLOT_W-1:0];
            end
            OP_PLACE_POP: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en_a) begin
            rd_a_reg <= heap_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            rd_b_reg <= heap_mem[rd_addr_b];
        end
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
    end

    // root shadow keeps the front readable without a memory port
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        if (wr_en && wr_addr == '0) begin
            root_reg <= wr_data;
        end
        if (cmd.op == OP_TAKE_LAST) begin
            top_reg <= root_reg;
        end
        if (cmd.op == OP_LOAD_ITEM) begin
            kind_reg <= s_tuser;
        end
        if (cmd.res_load) begin
            out_ok_reg            <= cmd.res_ok;
            out_reg.entry         <= res_entry;
            out_reg.entry_count   <= CNT_W'(count_reg);
            out_reg.is_empty      <= count_reg == '0;
            out_reg.is_full       <= count_reg == SLOT_W'(CAPACITY);
        end
    end

    always_comb begin
        if (!cmd.res_ok) begin
            res_entry = '0;
        end else if (cmd.res_pop) begin
            res_entry = top_reg;
        end else begin
            res_entry = root_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.full       = count_reg == SLOT_W'(CAPACITY);
    assign stat.empty      = count_reg == '0;
    assign stat.has_parent = slot_reg > SLOT_W'(1);
    assign stat.up_lt      = item_reg.distance < rd_a_reg.distance;
    assign stat.has_left   = left_slot <= count_ext;
    assign stat.down_gt    = item_reg.distance > chosen.distance;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_reg};

    `MHPQ_ASSERT_IMPL(a_up_below_root, aclk, aresetn, cmd.op == OP_MOVE_UP, slot_reg > SLOT_W'(1), "sift-up moved past the root")
    `MHPQ_ASSERT_IMPL(a_child_in_heap, aclk, aresetn, cmd.op == OP_RD_CHILD, left_slot <= count_ext, "child read beyond the heap")
    `MHPQ_ASSERT_NEXT(a_push_counts, aclk, aresetn, cmd.op == OP_PLACE_PUSH, count_reg == $past(count_reg) + 1'b1, "push did not grow the count")
    `MHPQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, cmd.op == OP_PLACE_PUSH, count_reg < SLOT_W'(CAPACITY), "push on a full heap")

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// sequencing state machine of the min-heap priority queue
// drives mhpq_dp by command and reads its status; depends on mhpq_pkg and the defines header
`include "min_heap_priority_queue_unit_defines.svh"

module mhpq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mhpq_pkg::dp_stat_t   stat,
    output mhpq_pkg::ctrl_cmd_t  cmd
);
    import mhpq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP_TEST,
        ST_UP_CMP,
        ST_TAKE_LAST,
        ST_DOWN_TEST,
        ST_DOWN_CMP,
        ST_DONE,
        ST_FAIL
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.res_load = 1'b0;
        cmd.res_ok   = 1'b0;
        cmd.res_pop  = stat.kind;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD_ITEM;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.kind == KIND_PUSH) begin
                    if (stat.full) begin
                        state_next = ST_FAIL;
                    end else begin
                        cmd.op     = OP_START_PUSH;
                        state_next = ST_UP_TEST;
                    end
                end else begin
                    if (stat.empty) begin
                        state_next = ST_FAIL;
                    end else begin
                        cmd.op     = OP_RD_LAST;
                        state_next = ST_TAKE_LAST;
                    end
                end
            end
            ST_UP_TEST: begin
                if (stat.has_parent) begin
                    cmd.op     = OP_RD_PARENT;
                    state_next = ST_UP_CMP;
                end else begin
                    cmd.op     = OP_PLACE_PUSH;
                    state_next = ST_DONE;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_lt) begin
                    cmd.op     = OP_MOVE_UP;
                    state_next = ST_UP_TEST;
                end else begin
                    cmd.op     = OP_PLACE_PUSH;
                    state_next = ST_DONE;
                end
            end
            ST_TAKE_LAST: begin
                cmd.op     = OP_TAKE_LAST;
                state_next = ST_DOWN_TEST;
            end
            ST_DOWN_TEST: begin
                if (stat.has_left) begin
                    cmd.op     = OP_RD_CHILD;
                    state_next = ST_DOWN_CMP;
                end else begin
                    cmd.op     = OP_PLACE_POP;
                    state_next = ST_DONE;
                end
            end
            ST_DOWN_CMP: begin
                if (stat.down_gt) begin
                    cmd.op     = OP_MOVE_DOWN;
                    state_next = ST_DOWN_TEST;
                end else begin
                    cmd.op     = OP_PLACE_POP;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_ok   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MHPQ_ASSERT_IMPL(a_load_when_free, aclk, aresetn, cmd.res_load, stat.out_free, "result loaded over an untaken one")
    `MHPQ_ASSERT_NEXT(a_accept_decides, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECIDE, "transfer not followed by decode")
    `MHPQ_ASSERT_IMPL(a_last_after_read, aclk, aresetn, state_reg == ST_TAKE_LAST, $past(state_reg) == ST_DECIDE, "last entry taken without a read")

endmodule

// ===== rtl/min_heap_priority_queue_unit.sv =====
// min-heap priority queue, top level: stream ports around the controller and datapath
// depends on mhpq_pkg, mhpq_ctrl and mhpq_dp
//
// usage: each input transfer is one operation, s_tuser selecting push (0) or pop (1).
// a push carries address, distance and visited mark in s_tdata; a pop ignores s_tdata.
// every operation gives exactly one result transfer: m_tuser is the ok flag, m_tdata
// the popped entry or the front after a push, the count and the empty and full flags.
// a refused push (heap full) or pop (heap empty) returns ok low with a zero entry.
// one operation is in work at a time; s_tready is high only while the unit waits.
// a push climbs the heap one parent at a time until a compare stops it or the root is
// reached; a pop moves the last entry to the root and descends one child pair at a time
// until a compare stops it or no child is left. the next transfer is taken at the
// earliest once the unit is back in idle after loading the result. each level takes a
// memory read and then a compare-and-write on the single-write, dual-read heap memory.
// the result register lets the next operation be taken and worked on while the
// previous result waits; the unit holds before loading a new result until it is taken.
// reset empties the queue and drops any pending result; the heap memory needs no
// clearing pass since only slots up to the count are used.
module min_heap_priority_queue_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // push_address[15:0], push_distance[31:16], push_visited[32], zero pad
    input  logic [mhpq_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_address[15:0], entry_distance[31:16], entry_visited[32],
    // entry_count[38:33], is_empty[39], is_full[40], zero pad
    output logic [mhpq_pkg::M_TDATA_W-1:0]  m_tdata,
    // ok[0]
    output logic                            m_tuser
);
    import mhpq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
